// File: src/ffdp_pkg.sv
// shared types, constants and helper functions of the first-fit placement core
`default_nettype none

package ffdp_pkg;

  // table size and derived widths
  localparam int NUM_SLOTS  = 8;
  localparam int UTIL_W     = 7;
  localparam int FREQ_W     = 6;
  localparam int COUNT_W    = 8;
  localparam int ENERGY_W   = 40;
  localparam int RUNTIME_W  = 16;
  localparam int TASK_E_W   = FREQ_W + RUNTIME_W;
  localparam int BASE_INC_W = RUNTIME_W + 5;
  localparam int SLOT_NUM_W = 4;
  localparam int MASK_W     = 16;
  localparam int TASKS_W    = 12;

  // totals are summed in groups, then the groups are summed
  localparam int GROUP_SIZE = 4;
  localparam int NUM_GROUPS = (NUM_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int ESUM_G_W   = ENERGY_W + $clog2(GROUP_SIZE);
  localparam int TOT_W      = ESUM_G_W + $clog2(NUM_GROUPS);
  localparam int TSUM_G_W   = COUNT_W + $clog2(GROUP_SIZE);

  localparam logic [ENERGY_W-1:0]   E_MAX       = {ENERGY_W{1'b1}};
  localparam logic [COUNT_W-1:0]    COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0]    COUNT_KEEP  = 8'd2;
  localparam logic [4:0]            BASE_TENTHS = 5'd30;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MID  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW  = 3'd6;

  localparam logic [UTIL_W-1:0] RST_HIGH_THR  = 7'd80;
  localparam logic [UTIL_W-1:0] RST_LOW_THR   = 7'd40;
  localparam logic [UTIL_W-1:0] RST_SLEEP_THR = 7'd50;
  localparam logic [UTIL_W-1:0] RST_CAP_LIMIT = 7'd100;
  localparam logic [FREQ_W-1:0] RST_FREQ_HIGH = 6'd30;
  localparam logic [FREQ_W-1:0] RST_FREQ_MID  = 6'd25;
  localparam logic [FREQ_W-1:0] RST_FREQ_LOW  = 6'd18;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_CONSOL  = 2'd1,
    OP_PLACE   = 2'd2,
    OP_REPORT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_PLACED         = 3'd0,
    ST_WOKE_PLACED    = 3'd1,
    ST_WOKE_TOO_LARGE = 3'd2,
    ST_UNSCHED        = 3'd3,
    ST_DONE           = 3'd4
  } status_e;

  typedef struct packed {
    logic [UTIL_W-1:0] high_thr;
    logic [UTIL_W-1:0] low_thr;
    logic [UTIL_W-1:0] sleep_thr;
    logic [UTIL_W-1:0] cap_limit;
    logic [FREQ_W-1:0] freq_high;
    logic [FREQ_W-1:0] freq_mid;
    logic [FREQ_W-1:0] freq_low;
  } cfg_t;

  typedef struct packed {
    logic [UTIL_W-1:0]   util;
    logic                asleep;
    logic [FREQ_W-1:0]   freq;
    logic [COUNT_W-1:0]  count;
    logic [ENERGY_W-1:0] energy;
  } slot_t;

  typedef struct packed {
    op_e                  opcode;
    logic [SLOT_NUM_W-1:0] slot_index;
    logic [UTIL_W-1:0]    init_util;
    logic [UTIL_W-1:0]    task_load;
    logic [RUNTIME_W-1:0] task_runtime;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_NUM_W-1:0] chosen;
    logic [FREQ_W-1:0]     freq;
    logic [TASK_E_W-1:0]   energy;
  } step_res_t;

  // frequency level for a utilization
  function automatic logic [FREQ_W-1:0] pick_freq(cfg_t cfg, logic [UTIL_W-1:0] util);
    logic [FREQ_W-1:0] f;
    if (util > cfg.high_thr) begin
      f = cfg.freq_high;
    end else if (util < cfg.low_thr) begin
      f = cfg.freq_low;
    end else begin
      f = cfg.freq_mid;
    end
    return f;
  endfunction

  // clamp a sum with one carry bit
  function automatic logic [ENERGY_W-1:0] sat_energy(logic [ENERGY_W:0] s);
    return s[ENERGY_W] ? E_MAX : s[ENERGY_W-1:0];
  endfunction

  // awake, emptied slot at the given utilization
  function automatic slot_t clear_slot(logic [UTIL_W-1:0] util, logic [FREQ_W-1:0] freq);
    slot_t s;
    s.util   = util;
    s.asleep = 1'b0;
    s.freq   = freq;
    s.count  = '0;
    s.energy = '0;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/first_fit_dvfs_placement_core.sv
// top level of the first-fit placement core with frequency scaling and energy totals
`default_nettype none

// usage
// - input channel (in_valid_i / in_ready_o) carries one operation per item:
//   init a slot, consolidate, place a task or report; one result item follows
//   each input item on the output channel (out_valid_o / out_ready_i)
// - configuration: cfg_we_i writes cfg_data_i into register cfg_index_i in the
//   same edge; indexes past the last register are dropped; write only when idle
// - pipeline of four registers: input register, table update, group sums of
//   the totals, output register; an accepted item passes them in that order
// - throughput one item per cycle unless the output stalls: the slot table lives
//   in flip-flops; the fit compare, priority pick and the 6x16 and 16x5
//   multiplies are combinational, between the input register and the table
// - totals over awake slots are summed in groups of four, then across groups
// - a stalled receiver holds the output register; earlier stages keep filling
//   until every stage is occupied, then in_ready_o drops
// - reset: all slots awake, empty, at the medium frequency; registers take
//   their defaults; no clearing pass, items are taken right after reset

module first_fit_dvfs_placement_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             opcode_i,
  input  logic [ffdp_pkg::SLOT_NUM_W-1:0]        slot_index_i,
  input  logic [ffdp_pkg::UTIL_W-1:0]            init_utilization_i,
  input  logic [ffdp_pkg::UTIL_W-1:0]            task_load_i,
  input  logic [ffdp_pkg::RUNTIME_W-1:0]         task_runtime_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [2:0]                             status_o,
  output logic [ffdp_pkg::SLOT_NUM_W-1:0]        chosen_slot_o,
  output logic [ffdp_pkg::FREQ_W-1:0]            freq_tenths_o,
  output logic [ffdp_pkg::TASK_E_W-1:0]          task_energy_o,
  output logic [ffdp_pkg::MASK_W-1:0]            sleep_mask_o,
  output logic [ffdp_pkg::ENERGY_W-1:0]          awake_energy_o,
  output logic [ffdp_pkg::TASKS_W-1:0]           awake_tasks_o,
  output logic [ffdp_pkg::ENERGY_W-1:0]          baseline_total_o,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [ffdp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ffdp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int N  = ffdp_pkg::NUM_SLOTS;
  localparam int NG = ffdp_pkg::NUM_GROUPS;
  localparam int GS = ffdp_pkg::GROUP_SIZE;

  // stage enables, back to front
  logic en0, en1, en2, en3;

  // configuration registers
  ffdp_pkg::cfg_t cfg_q, cfg_d;

  // stage 0: input register
  logic            v0_q, v0_d;
  ffdp_pkg::item_t item_q;

  // stage 1: slot table and step result
  logic                                 v1_q, v1_d;
  ffdp_pkg::step_res_t                  res1_q, res1_d;
  ffdp_pkg::slot_t [N-1:0]              slots_q, slots_d;
  logic [ffdp_pkg::ENERGY_W-1:0]        baseline_q, baseline_d;

  // stage 2: group sums
  logic                                 v2_q, v2_d;
  ffdp_pkg::step_res_t                  res2_q;
  logic [ffdp_pkg::ESUM_G_W-1:0]        esum_q [NG];
  logic [ffdp_pkg::ESUM_G_W-1:0]        esum_d [NG];
  logic [ffdp_pkg::TSUM_G_W-1:0]        tsum_q [NG];
  logic [ffdp_pkg::TSUM_G_W-1:0]        tsum_d [NG];
  logic [ffdp_pkg::MASK_W-1:0]          mask2_q, mask2_d;
  logic [ffdp_pkg::ENERGY_W-1:0]        base2_q;

  // stage 3: output register
  logic                                 v3_q, v3_d;
  logic [ffdp_pkg::TOT_W-1:0]           tot_e;
  logic [ffdp_pkg::TASKS_W-1:0]         tot_t;
  ffdp_pkg::step_res_t                  res3_q;
  logic [ffdp_pkg::MASK_W-1:0]          mask3_q;
  logic [ffdp_pkg::ENERGY_W-1:0]        tot_e3_q, base3_q;
  logic [ffdp_pkg::TASKS_W-1:0]         tot_t3_q;

  // a stage moves when it is empty or the one behind it moves
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ffdp_pkg::REG_HIGH_THR:  cfg_d.high_thr  = cfg_data_i;
        ffdp_pkg::REG_LOW_THR:   cfg_d.low_thr   = cfg_data_i;
        ffdp_pkg::REG_SLEEP_THR: cfg_d.sleep_thr = cfg_data_i;
        ffdp_pkg::REG_CAP_LIMIT: cfg_d.cap_limit = cfg_data_i;
        ffdp_pkg::REG_FREQ_HIGH: cfg_d.freq_high = cfg_data_i[ffdp_pkg::FREQ_W-1:0];
        ffdp_pkg::REG_FREQ_MID:  cfg_d.freq_mid  = cfg_data_i[ffdp_pkg::FREQ_W-1:0];
        ffdp_pkg::REG_FREQ_LOW:  cfg_d.freq_low  = cfg_data_i[ffdp_pkg::FREQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // operation logic on the table
  ffdp_pkg::slot_t [N-1:0]       step_slots;
  logic [ffdp_pkg::ENERGY_W-1:0] step_baseline;

  ffdp_step u_step (
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .slots_i    (slots_q),
    .baseline_i (baseline_q),
    .slots_o    (step_slots),
    .baseline_o (step_baseline),
    .res_o      (res1_d)
  );

  // the table only changes when stage 1 takes an item
  assign slots_d    = (v0_q && en1) ? step_slots : slots_q;
  assign baseline_d = (v0_q && en1) ? step_baseline : baseline_q;

  // valid flags
  assign v0_d = en0 ? in_valid_i : v0_q;
  assign v1_d = en1 ? v0_q : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;

  // group sums read the table while it still holds the state after the
  // item in stage 1: the table cannot move unless stage 2 also loads
  always_comb begin
    mask2_d = '0;
    for (int g = 0; g < NG; g++) begin
      esum_d[g] = '0;
      tsum_d[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < N) begin
          if (!slots_q[g * GS + k].asleep) begin
            esum_d[g] = esum_d[g] + ffdp_pkg::ESUM_G_W'(slots_q[g * GS + k].energy);
            tsum_d[g] = tsum_d[g] + ffdp_pkg::TSUM_G_W'(slots_q[g * GS + k].count);
          end
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      mask2_d[i] = slots_q[i].asleep;
    end
  end

  // final totals across groups
  always_comb begin
    tot_e = '0;
    tot_t = '0;
    for (int g = 0; g < NG; g++) begin
      tot_e = tot_e + ffdp_pkg::TOT_W'(esum_q[g]);
      tot_t = tot_t + ffdp_pkg::TASKS_W'(tsum_q[g]);
    end
  end

  // control state and the slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr  <= ffdp_pkg::RST_HIGH_THR;
      cfg_q.low_thr   <= ffdp_pkg::RST_LOW_THR;
      cfg_q.sleep_thr <= ffdp_pkg::RST_SLEEP_THR;
      cfg_q.cap_limit <= ffdp_pkg::RST_CAP_LIMIT;
      cfg_q.freq_high <= ffdp_pkg::RST_FREQ_HIGH;
      cfg_q.freq_mid  <= ffdp_pkg::RST_FREQ_MID;
      cfg_q.freq_low  <= ffdp_pkg::RST_FREQ_LOW;
      for (int i = 0; i < N; i++) begin
        slots_q[i] <= ffdp_pkg::clear_slot('0, ffdp_pkg::RST_FREQ_MID);
      end
      baseline_q <= '0;
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      slots_q    <= slots_d;
      baseline_q <= baseline_d;
      v0_q       <= v0_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      v3_q       <= v3_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && en0) begin
      item_q.opcode       <= ffdp_pkg::op_e'(opcode_i);
      item_q.slot_index   <= slot_index_i;
      item_q.init_util    <= init_utilization_i;
      item_q.task_load    <= task_load_i;
      item_q.task_runtime <= task_runtime_i;
    end
    if (v0_q && en1) begin
      res1_q <= res1_d;
    end
    if (v1_q && en2) begin
      res2_q  <= res1_q;
      mask2_q <= mask2_d;
      base2_q <= baseline_q;
      for (int g = 0; g < NG; g++) begin
        esum_q[g] <= esum_d[g];
        tsum_q[g] <= tsum_d[g];
      end
    end
    if (v2_q && en3) begin
      res3_q   <= res2_q;
      mask3_q  <= mask2_q;
      base3_q  <= base2_q;
      tot_e3_q <= (tot_e > ffdp_pkg::TOT_W'(ffdp_pkg::E_MAX)) ? ffdp_pkg::E_MAX :
                  tot_e[ffdp_pkg::ENERGY_W-1:0];
      tot_t3_q <= tot_t;
    end
  end

  assign out_valid_o      = v3_q;
  assign status_o         = res3_q.status;
  assign chosen_slot_o    = res3_q.chosen;
  assign freq_tenths_o    = res3_q.freq;
  assign task_energy_o    = res3_q.energy;
  assign sleep_mask_o     = mask3_q;
  assign awake_energy_o   = tot_e3_q;
  assign awake_tasks_o    = tot_t3_q;
  assign baseline_total_o = base3_q;

  // checks

  // input side only stalls when the output register is full and held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output free");

  // operations other than place report no slot, frequency or energy
  a_done_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ffdp_pkg::ST_DONE) |->
    (chosen_slot_o == '0 && freq_tenths_o == '0 && task_energy_o == '0))
    else $error("done result carries placement fields");

  // an unscheduled task leaves no trace in the result
  a_unsched_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ffdp_pkg::ST_UNSCHED) |->
    (chosen_slot_o == '0 && task_energy_o == '0 && sleep_mask_o == '0))
    else $error("unscheduled result inconsistent");

  // no sleep flags beyond the table
  a_mask_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sleep_mask_o >> N) == '0))
    else $error("sleep mask bit beyond table");

endmodule

`default_nettype wire

// File: src/ffdp_step.sv
// slot table update and result of one operation
`default_nettype none

module ffdp_step (
  input  ffdp_pkg::item_t                             item_i,
  input  ffdp_pkg::cfg_t                              cfg_i,
  input  ffdp_pkg::slot_t [ffdp_pkg::NUM_SLOTS-1:0]   slots_i,
  input  logic [ffdp_pkg::ENERGY_W-1:0]               baseline_i,
  output ffdp_pkg::slot_t [ffdp_pkg::NUM_SLOTS-1:0]   slots_o,
  output logic [ffdp_pkg::ENERGY_W-1:0]               baseline_o,
  output ffdp_pkg::step_res_t                         res_o
);

  localparam int N = ffdp_pkg::NUM_SLOTS;

  logic [N-1:0] awake_fit_v, asleep_v, fit_oh, sleep_oh, sel_oh;
  logic         found_fit, found_sleep, empty_fits, place_op, do_place, wake_only;
  logic [ffdp_pkg::SLOT_NUM_W-1:0] fit_idx, sleep_idx, sel_idx;
  logic [ffdp_pkg::UTIL_W-1:0]     base_util, new_util;
  logic [ffdp_pkg::COUNT_W-1:0]    base_count, new_count;
  logic [ffdp_pkg::ENERGY_W-1:0]   base_energy, new_energy;
  logic [ffdp_pkg::FREQ_W-1:0]     new_freq;
  logic [ffdp_pkg::TASK_E_W-1:0]   task_e;
  logic [ffdp_pkg::BASE_INC_W-1:0] base_inc;

  // fit test and sleep flags per slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      asleep_v[i]    = slots_i[i].asleep;
      awake_fit_v[i] = !slots_i[i].asleep &&
                       (({1'b0, slots_i[i].util} + {1'b0, item_i.task_load})
                        <= {1'b0, cfg_i.cap_limit});
    end
  end

  // lowest set bit wins
  assign fit_oh   = awake_fit_v & (~awake_fit_v + N'(1));
  assign sleep_oh = asleep_v & (~asleep_v + N'(1));

  always_comb begin
    fit_idx   = '0;
    sleep_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (fit_oh[i]) fit_idx = fit_idx | ffdp_pkg::SLOT_NUM_W'(i);
      if (sleep_oh[i]) sleep_idx = sleep_idx | ffdp_pkg::SLOT_NUM_W'(i);
    end
  end

  assign found_fit   = |awake_fit_v;
  assign found_sleep = |asleep_v;
  assign sel_oh      = found_fit ? fit_oh : sleep_oh;
  assign sel_idx     = found_fit ? fit_idx : sleep_idx;
  assign empty_fits  = {1'b0, item_i.task_load} <= {1'b0, cfg_i.cap_limit};
  assign place_op    = (item_i.opcode == ffdp_pkg::OP_PLACE);
  assign do_place    = place_op && (found_fit || (found_sleep && empty_fits));
  assign wake_only   = place_op && !found_fit && found_sleep && !empty_fits;

  // a woken slot starts from an empty state
  always_comb begin
    base_util   = '0;
    base_count  = '0;
    base_energy = '0;
    for (int i = 0; i < N; i++) begin
      if (found_fit && sel_oh[i]) begin
        base_util   = base_util | slots_i[i].util;
        base_count  = base_count | slots_i[i].count;
        base_energy = base_energy | slots_i[i].energy;
      end
    end
  end

  assign new_util   = ffdp_pkg::UTIL_W'({1'b0, base_util} + {1'b0, item_i.task_load});
  assign new_count  = (base_count == ffdp_pkg::COUNT_MAX) ? base_count :
                      base_count + ffdp_pkg::COUNT_W'(1);
  assign new_freq   = ffdp_pkg::pick_freq(cfg_i, new_util);
  assign task_e     = ffdp_pkg::TASK_E_W'(new_freq) * ffdp_pkg::TASK_E_W'(item_i.task_runtime);
  assign new_energy = ffdp_pkg::sat_energy({1'b0, base_energy} +
                                           (ffdp_pkg::ENERGY_W + 1)'(task_e));
  assign base_inc   = ffdp_pkg::BASE_INC_W'(item_i.task_runtime) *
                      ffdp_pkg::BASE_INC_W'(ffdp_pkg::BASE_TENTHS);

  // next table contents
  always_comb begin
    slots_o    = slots_i;
    baseline_o = baseline_i;
    case (item_i.opcode)
      ffdp_pkg::OP_INIT: begin
        for (int i = 0; i < N; i++) begin
          if (item_i.slot_index == ffdp_pkg::SLOT_NUM_W'(i)) begin
            slots_o[i] = ffdp_pkg::clear_slot(item_i.init_util, cfg_i.freq_mid);
          end
        end
      end
      ffdp_pkg::OP_CONSOL: begin
        for (int i = 0; i < N; i++) begin
          if ((slots_i[i].util < cfg_i.sleep_thr) &&
              (slots_i[i].count < ffdp_pkg::COUNT_KEEP)) begin
            slots_o[i].asleep = 1'b1;
          end
        end
      end
      ffdp_pkg::OP_PLACE: begin
        for (int i = 0; i < N; i++) begin
          if (sel_oh[i] && do_place) begin
            slots_o[i].util   = new_util;
            slots_o[i].asleep = 1'b0;
            slots_o[i].freq   = new_freq;
            slots_o[i].count  = new_count;
            slots_o[i].energy = new_energy;
          end else if (sel_oh[i] && wake_only) begin
            slots_o[i] = ffdp_pkg::clear_slot('0, cfg_i.freq_mid);
          end
        end
        if (do_place) begin
          baseline_o = ffdp_pkg::sat_energy({1'b0, baseline_i} +
                                            (ffdp_pkg::ENERGY_W + 1)'(base_inc));
        end
      end
      default: begin
      end
    endcase
  end

  // per-operation result fields
  always_comb begin
    res_o.status = ffdp_pkg::ST_DONE;
    res_o.chosen = '0;
    res_o.freq   = '0;
    res_o.energy = '0;
    if (place_op) begin
      if (found_fit || found_sleep) begin
        res_o.chosen = sel_idx;
        if (do_place) begin
          res_o.status = found_fit ? ffdp_pkg::ST_PLACED : ffdp_pkg::ST_WOKE_PLACED;
          res_o.freq   = new_freq;
          res_o.energy = task_e;
        end else begin
          res_o.status = ffdp_pkg::ST_WOKE_TOO_LARGE;
          res_o.freq   = cfg_i.freq_mid;
        end
      end else begin
        res_o.status = ffdp_pkg::ST_UNSCHED;
      end
    end
  end

endmodule

`default_nettype wire
